// ===== rtl/core/mcmf_pkg.sv =====
// ----------------------------------------------------------------------------
// mcmf_pkg
// Shared widths, limits and status codes of the min-cost max-flow solver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcmf_pkg;

    localparam int MAX_NODES = 16;
    localparam int MAX_EDGES = 32;
    localparam int CAP_W     = 16;

    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int EADDR_W   = $clog2(MAX_EDGES);
    localparam int ECNT_W    = EADDR_W + 1;
    localparam int NCNT_W    = NODE_W + 1;
    localparam int DIST_W    = 6;
    localparam int SUM_W     = 21;
    localparam int COST_W    = 27;

    // edge memory word: {capacity, head, tail}
    localparam int EDGE_W    = CAP_W + 2 * NODE_W;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 88;
    localparam int STAT_W     = 2;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_NODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SINK_NODE   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_SAME  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/min_cost_max_flow_solver.sv =====
// ----------------------------------------------------------------------------
// min_cost_max_flow_solver
// Loads directed unit-cost edges, solves min-cost max-flow by successive
// shortest paths (Bellman-Ford) and reports the flow of every edge.
// ----------------------------------------------------------------------------
//  channel   | dir | request contents
//  s_axis    | in  | tdata {capacity, to_node, from_node}, tlast last_edge
//  m_axis    | out | tdata {total_cost, total_flow, edge_flow, edge_capacity,
//            |     |        edge_to, edge_from, edge_index}, tuser status,
//            |     |        tlast last_result
//  cfg       | in  | cfg_wr_en, cfg_index, cfg_data (write only)
//
// edges load one per cycle; the request with tlast starts the solve.
// solve: each loaded edge is read to clear its flow, then per augmenting path
// (n-1) rounds scan every loaded edge for each reached node over the single
// edge memory read port, then the path is walked twice; results wait for tready.
// s_axis_tready is low from the last edge until the final result is taken.
// reset empties the edge table and sets node_count 16, source 0, sink 15.
`timescale 1ns / 1ps
`default_nettype none

module min_cost_max_flow_solver (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // capacity[23:8], to_node[7:4], from_node[3:0]
    input  wire logic [mcmf_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tlast,
    output logic                                   s_axis_tready,
    // total_cost[86:66], total_flow[65:45], edge_flow[44:29],
    // edge_capacity[28:13], edge_to[12:9], edge_from[8:5], edge_index[4:0]
    output logic [mcmf_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // status[1:0]
    output logic [mcmf_pkg::STAT_W-1:0]            m_axis_tuser,
    output logic                                   m_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic                              cfg_wr_en,
    input  wire logic [mcmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mcmf_pkg::CFG_W-1:0]        cfg_data
);

    import mcmf_pkg::*;

    localparam logic [4:0] S_LOAD     = 5'd0;
    localparam logic [4:0] S_CLR_RD   = 5'd1;
    localparam logic [4:0] S_CLR_EV   = 5'd2;
    localparam logic [4:0] S_CLR_END  = 5'd3;
    localparam logic [4:0] S_BF_INIT  = 5'd4;
    localparam logic [4:0] S_BF_U     = 5'd5;
    localparam logic [4:0] S_BF_RD    = 5'd6;
    localparam logic [4:0] S_BF_EV    = 5'd7;
    localparam logic [4:0] S_BF_CHK   = 5'd8;
    localparam logic [4:0] S_WK_RD    = 5'd9;
    localparam logic [4:0] S_WK_EV    = 5'd10;
    localparam logic [4:0] S_WK_END   = 5'd11;
    localparam logic [4:0] S_AUG_RD   = 5'd12;
    localparam logic [4:0] S_AUG_WR   = 5'd13;
    localparam logic [4:0] S_COST     = 5'd14;
    localparam logic [4:0] S_ACC      = 5'd15;
    localparam logic [4:0] S_OUT_RD   = 5'd16;
    localparam logic [4:0] S_OUT_CAP  = 5'd17;
    localparam logic [4:0] S_OUT_HOLD = 5'd18;

    logic [4:0]            state_reg;
    logic [NCNT_W-1:0]     node_count_reg;
    logic [NODE_W-1:0]     source_reg;
    logic [NODE_W-1:0]     sink_reg;
    logic [ECNT_W-1:0]     loaded_reg;
    logic [ECNT_W-1:0]     k_reg;
    logic [NCNT_W-1:0]     u_reg;
    logic [NCNT_W-1:0]     round_reg;
    logic [NODE_W-1:0]     v_reg;
    logic [NCNT_W-1:0]     steps_reg;
    logic [CAP_W-1:0]      push_reg;
    logic                  push_inf_reg;
    logic                  bad_edge_reg;
    logic [STAT_W-1:0]     status_reg;
    logic [SUM_W:0]        flow_sum_reg;
    logic signed [COST_W-1:0] cost_sum_reg;
    logic signed [CAP_W+DIST_W:0] prod_reg;

    logic signed [DIST_W-1:0] dist_reg [MAX_NODES];
    logic                     reached_reg [MAX_NODES];
    logic [EADDR_W:0]         par_reg [MAX_NODES];
    logic                     pvalid_reg [MAX_NODES];

    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [STAT_W-1:0]     out_user_reg;
    logic                  out_last_reg;
    logic                  out_valid_reg;

    // memory ports
    logic                  e_we;
    logic [EADDR_W-1:0]    e_waddr;
    logic [EDGE_W-1:0]     e_wdata;
    logic [EADDR_W-1:0]    raddr;
    logic [EDGE_W-1:0]     e_rdata;
    logic                  f_we;
    logic [EADDR_W-1:0]    f_waddr;
    logic [CAP_W-1:0]      f_wdata;
    logic [CAP_W-1:0]      f_rdata;

    logic [NCNT_W-1:0]     n_eff;
    logic [NODE_W-1:0]     e_tail;
    logic [NODE_W-1:0]     e_head;
    logic [CAP_W-1:0]      e_cap;
    logic                  e_ok;
    logic [EADDR_W:0]      par_v;
    logic signed [DIST_W-1:0] d_u;
    logic signed [DIST_W-1:0] d_fwd;
    logic signed [DIST_W-1:0] d_rev;
    logic                  fire_fwd;
    logic                  fire_rev;
    logic [CAP_W-1:0]      resid;
    logic                  k_last;
    logic                  in_acc;

    assign n_eff = (node_count_reg == '0) ? NCNT_W'(1) :
                   (node_count_reg > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) :
                   node_count_reg;

    assign e_tail = e_rdata[NODE_W-1:0];
    assign e_head = e_rdata[2*NODE_W-1:NODE_W];
    assign e_cap  = e_rdata[EDGE_W-1:2*NODE_W];
    assign e_ok   = ({1'b0, e_tail} < n_eff) && ({1'b0, e_head} < n_eff);
    assign par_v  = par_reg[v_reg];
    assign k_last = (ECNT_W'(k_reg + 1'b1) == loaded_reg);
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // relaxation of one residual edge pair around node u
    assign d_u   = dist_reg[u_reg[NODE_W-1:0]];
    assign d_fwd = d_u + DIST_W'(1);
    assign d_rev = d_u - DIST_W'(1);
    assign fire_fwd = e_ok && (e_tail == u_reg[NODE_W-1:0]) && (e_cap > f_rdata)
                   && (!reached_reg[e_head] || (dist_reg[e_head] > d_fwd));
    assign fire_rev = e_ok && (e_head == u_reg[NODE_W-1:0]) && (f_rdata != '0)
                   && (!reached_reg[e_tail] || (dist_reg[e_tail] > d_rev));

    assign resid = par_v[0] ? f_rdata : CAP_W'(e_cap - f_rdata);

    always_comb
    begin
        e_we    = in_acc && (loaded_reg < ECNT_W'(MAX_EDGES));
        e_waddr = loaded_reg[EADDR_W-1:0];
        e_wdata = {s_axis_tdata[2*NODE_W+CAP_W-1:2*NODE_W],
                   s_axis_tdata[2*NODE_W-1:NODE_W], s_axis_tdata[NODE_W-1:0]};
        unique case (state_reg)
            S_WK_RD, S_WK_EV, S_AUG_RD, S_AUG_WR: raddr = par_v[EADDR_W:1];
            default:                              raddr = k_reg[EADDR_W-1:0];
        endcase
        f_we    = (state_reg == S_CLR_RD) || (state_reg == S_AUG_WR);
        f_waddr = (state_reg == S_AUG_WR) ? par_v[EADDR_W:1] : k_reg[EADDR_W-1:0];
        if (state_reg == S_AUG_WR)
        begin
            f_wdata = par_v[0] ? CAP_W'(f_rdata - push_reg) : CAP_W'(f_rdata + push_reg);
        end
        else
        begin
            f_wdata = '0;
        end
    end

    mcmf_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (raddr),
        .rdata (e_rdata)
    );

    mcmf_ram #(.WIDTH(CAP_W), .DEPTH(MAX_EDGES)) u_flow_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (raddr),
        .rdata (f_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NCNT_W'(MAX_NODES);
            source_reg     <= '0;
            sink_reg       <= NODE_W'(MAX_NODES - 1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_NODE_COUNT:  node_count_reg <= cfg_data[NCNT_W-1:0];
                REG_SOURCE_NODE: source_reg     <= cfg_data[NODE_W-1:0];
                REG_SINK_NODE:   sink_reg       <= cfg_data[NODE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            loaded_reg    <= '0;
            k_reg         <= '0;
            u_reg         <= '0;
            round_reg     <= '0;
            v_reg         <= '0;
            steps_reg     <= '0;
            push_reg      <= '0;
            push_inf_reg  <= 1'b1;
            bad_edge_reg  <= 1'b0;
            status_reg    <= ST_OK;
            flow_sum_reg  <= '0;
            cost_sum_reg  <= '0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_NODES; i++)
            begin
                reached_reg[i] <= 1'b0;
                pvalid_reg[i]  <= 1'b0;
                dist_reg[i]    <= '0;
                par_reg[i]     <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (loaded_reg < ECNT_W'(MAX_EDGES))
                        begin
                            loaded_reg <= ECNT_W'(loaded_reg + 1'b1);
                        end
                        if (s_axis_tlast)
                        begin
                            k_reg        <= '0;
                            bad_edge_reg <= 1'b0;
                            flow_sum_reg <= '0;
                            cost_sum_reg <= '0;
                            state_reg    <= S_CLR_RD;
                        end
                    end
                end
                S_CLR_RD:
                begin
                    state_reg <= S_CLR_EV;
                end
                S_CLR_EV:
                begin
                    if (!e_ok)
                    begin
                        bad_edge_reg <= 1'b1;
                    end
                    if (k_last)
                    begin
                        state_reg <= S_CLR_END;
                    end
                    else
                    begin
                        k_reg     <= ECNT_W'(k_reg + 1'b1);
                        state_reg <= S_CLR_RD;
                    end
                end
                S_CLR_END:
                begin
                    k_reg <= '0;
                    priority if (source_reg == sink_reg)
                    begin
                        status_reg <= ST_SAME;
                        state_reg  <= S_OUT_RD;
                    end
                    else if (({1'b0, source_reg} >= n_eff) || ({1'b0, sink_reg} >= n_eff))
                    begin
                        status_reg <= ST_RANGE;
                        state_reg  <= S_OUT_RD;
                    end
                    else
                    begin
                        status_reg <= bad_edge_reg ? ST_RANGE : ST_OK;
                        state_reg  <= S_BF_INIT;
                    end
                end
                S_BF_INIT:
                begin
                    for (int i = 0; i < MAX_NODES; i++)
                    begin
                        reached_reg[i] <= 1'b0;
                        pvalid_reg[i]  <= 1'b0;
                    end
                    reached_reg[source_reg] <= 1'b1;
                    dist_reg[source_reg]    <= '0;
                    u_reg     <= '0;
                    round_reg <= NCNT_W'(1);
                    state_reg <= (n_eff > NCNT_W'(1)) ? S_BF_U : S_BF_CHK;
                end
                S_BF_U:
                begin
                    k_reg <= '0;
                    priority if (u_reg == n_eff)
                    begin
                        u_reg <= '0;
                        if (round_reg == NCNT_W'(n_eff - 1'b1))
                        begin
                            state_reg <= S_BF_CHK;
                        end
                        else
                        begin
                            round_reg <= NCNT_W'(round_reg + 1'b1);
                        end
                    end
                    else if (!reached_reg[u_reg[NODE_W-1:0]])
                    begin
                        u_reg <= NCNT_W'(u_reg + 1'b1);
                    end
                    else
                    begin
                        state_reg <= S_BF_RD;
                    end
                end
                S_BF_RD:
                begin
                    state_reg <= S_BF_EV;
                end
                S_BF_EV:
                begin
                    // both cannot fire for the same target (self loop never improves)
                    if (fire_fwd)
                    begin
                        reached_reg[e_head] <= 1'b1;
                        dist_reg[e_head]    <= d_fwd;
                        par_reg[e_head]     <= {k_reg[EADDR_W-1:0], 1'b0};
                        pvalid_reg[e_head]  <= 1'b1;
                    end
                    if (fire_rev)
                    begin
                        reached_reg[e_tail] <= 1'b1;
                        dist_reg[e_tail]    <= d_rev;
                        par_reg[e_tail]     <= {k_reg[EADDR_W-1:0], 1'b1};
                        pvalid_reg[e_tail]  <= 1'b1;
                    end
                    if (k_last)
                    begin
                        u_reg     <= NCNT_W'(u_reg + 1'b1);
                        state_reg <= S_BF_U;
                    end
                    else
                    begin
                        k_reg     <= ECNT_W'(k_reg + 1'b1);
                        state_reg <= S_BF_RD;
                    end
                end
                S_BF_CHK:
                begin
                    k_reg        <= '0;
                    v_reg        <= sink_reg;
                    steps_reg    <= '0;
                    push_inf_reg <= 1'b1;
                    state_reg    <= reached_reg[sink_reg] ? S_WK_RD : S_OUT_RD;
                end
                S_WK_RD:
                begin
                    if ((v_reg == source_reg) || (steps_reg >= n_eff) || !pvalid_reg[v_reg])
                    begin
                        state_reg <= S_WK_END;
                    end
                    else
                    begin
                        state_reg <= S_WK_EV;
                    end
                end
                S_WK_EV:
                begin
                    if (push_inf_reg || (resid < push_reg))
                    begin
                        push_reg     <= resid;
                        push_inf_reg <= 1'b0;
                    end
                    v_reg     <= par_v[0] ? e_head : e_tail;
                    steps_reg <= NCNT_W'(steps_reg + 1'b1);
                    state_reg <= S_WK_RD;
                end
                S_WK_END:
                begin
                    k_reg <= '0;
                    if ((v_reg != source_reg) || push_inf_reg || (push_reg == '0))
                    begin
                        state_reg <= S_OUT_RD;
                    end
                    else
                    begin
                        v_reg     <= sink_reg;
                        state_reg <= S_AUG_RD;
                    end
                end
                S_AUG_RD:
                begin
                    state_reg <= (v_reg == source_reg) ? S_COST : S_AUG_WR;
                end
                S_AUG_WR:
                begin
                    v_reg     <= par_v[0] ? e_head : e_tail;
                    state_reg <= S_AUG_RD;
                end
                S_COST:
                begin
                    flow_sum_reg <= (SUM_W+1)'(flow_sum_reg + push_reg);
                    prod_reg     <= $signed({1'b0, push_reg}) * dist_reg[sink_reg];
                    state_reg    <= S_ACC;
                end
                S_ACC:
                begin
                    cost_sum_reg <= COST_W'(cost_sum_reg + COST_W'(prod_reg));
                    state_reg    <= S_BF_INIT;
                end
                S_OUT_RD:
                begin
                    state_reg <= S_OUT_CAP;
                end
                S_OUT_CAP:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT_HOLD;
                end
                S_OUT_HOLD:
                begin
                    if (m_axis_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (k_last)
                        begin
                            loaded_reg <= '0;
                            state_reg  <= S_LOAD;
                        end
                        else
                        begin
                            k_reg     <= ECNT_W'(k_reg + 1'b1);
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT_CAP)
        begin
            out_data_reg <= {1'b0,
                             cost_sum_reg[COST_W-1] ? SUM_W'(0) : cost_sum_reg[SUM_W-1:0],
                             flow_sum_reg[SUM_W-1:0],
                             f_rdata, e_cap, e_head, e_tail,
                             k_reg[EADDR_W-1:0]};
            out_user_reg <= status_reg;
            out_last_reg <= k_last;
        end
    end

    assign s_axis_tready = (state_reg == S_LOAD);
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mcmf_ram.sv =====
// ----------------------------------------------------------------------------
// mcmf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
